// ----- hw/rtl/periodic_scan_window_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Periodic scan window scheduler: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SCAN_WINDOW_SCHEDULER_DEFINES_SVH
`define PERIODIC_SCAN_WINDOW_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/psws_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic scan window scheduler package
// Widths, action and register codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package psws_pkg;

  localparam int TIME_BITS = 48;
  localparam int CNT_W     = $clog2(TIME_BITS);
  localparam int ACT_W     = 2;
  localparam int DUR_W     = 16;
  localparam int PERIOD_W  = 24;
  localparam int PHASE_W   = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_POLL   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BEACON = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FORCE  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_B2B      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE    = 2'd3;

  localparam logic [DUR_W-1:0]    DURATION_RESET = 16'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 24'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLL,
    S_DIV,
    S_ALIGN,
    S_FINISH
  } state_t;

  // Controls for the bit-serial remainder unit.
  typedef struct packed {
    logic clear;
    logic step;
    logic shift;
    logic din;
  } div_ctl_t;

endpackage

// ----- hw/rtl/psws_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per step, most significant bit first.
// ----------------------------------------------------------------------------
module psws_div
  import psws_pkg::*;
(
  input  logic                clk,
  input  div_ctl_t            ctl,
  input  logic [PERIOD_W-1:0] period,
  output logic [PERIOD_W-1:0] rem
);

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W+1:0] diff;

  assign trial = {rem, ctl.din};
  assign diff  = {1'b0, trial} - {2'b00, period};

  // After the last step the remainder is shifted out LSB first.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= diff[PERIOD_W+1] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
    end else if (ctl.shift) begin
      rem <= {1'b0, rem[PERIOD_W-1:1]};
    end
  end

endmodule

// ----- hw/rtl/periodic_scan_window_scheduler.sv -----
// ----------------------------------------------------------------------------
// Periodic scan window scheduler: one transfer in, one transfer out per item.
// Poll, force and ignored items go straight to FINISH; locked polls run POLL.
// An aligning beacon runs DIV (skipped for a zero period), then adds in ALIGN.
// The adder and the remainder loop are both bit-serial.
// Synchronous reset unlocks, zeroes the schedule and loads register defaults.
// ----------------------------------------------------------------------------
module periodic_scan_window_scheduler
  import psws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [ACT_W-1:0]     action,
  input  logic [TIME_BITS-1:0] time_now,
  input  logic                 scan_busy,
  input  logic [TIME_BITS-1:0] beacon_time,
  // Result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 start_scan,
  output logic [DUR_W-1:0]     duration,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  `include "periodic_scan_window_scheduler_defines.svh"

  // Configuration registers.
  logic                 reg_b2b;
  logic [DUR_W-1:0]     reg_duration;
  logic [PERIOD_W-1:0]  reg_period;
  logic [PHASE_W-1:0]   reg_phase;

  // Scheduler state.
  logic                 is_locked;
  logic [TIME_BITS-1:0] nst;

  // Sequencer.
  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     cnt;
  logic                 cnt_last;

  // Serial datapath registers.
  logic [TIME_BITS-1:0] osh;
  logic [TIME_BITS-1:0] ssh;
  logic [PERIOD_W-1:0]  psh;
  logic [PHASE_W-1:0]   phsh;
  logic [1:0]           cy;
  logic                 bw;
  logic                 start_r;

  // Combinational helpers.
  logic                 accept;
  logic                 slot_free;
  logic                 load_result;
  logic                 now_zero;
  logic                 cfg_write;
  div_ctl_t             div_ctl;
  logic [PERIOD_W-1:0]  rem;

  logic                 add_a;
  logic                 add_nr;
  logic                 add_ph;
  logic [2:0]           add_total;
  logic                 bw_next;
  logic [TIME_BITS-1:0] ssh_next;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so every access is a single-wait-free transfer. The register index
  // is taken from the word address.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_b2b      <= 1'b0;
      reg_duration <= DURATION_RESET;
      reg_period   <= PERIOD_RESET;
      reg_phase    <= '0;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_B2B:      reg_b2b      <= pwdata[0];
        REG_DURATION: reg_duration <= pwdata[DUR_W-1:0];
        REG_PERIOD:   reg_period   <= pwdata[PERIOD_W-1:0];
        REG_PHASE:    reg_phase    <= pwdata[PHASE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_B2B:      prdata = {{(DATA_W-1){1'b0}}, reg_b2b};
      REG_DURATION: prdata = {{(DATA_W-DUR_W){1'b0}}, reg_duration};
      REG_PERIOD:   prdata = {{(DATA_W-PERIOD_W){1'b0}}, reg_period};
      REG_PHASE:    prdata = {{(DATA_W-PHASE_W){1'b0}}, reg_phase};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer. One item is worked on at a time. Items that need no time
  // arithmetic go straight to FINISH. A locked poll walks both the current
  // time and the next scan time LSB first through POLL, comparing and
  // adding one period in the same pass. An aligning beacon first runs the
  // remainder loop in DIV (MSB first), then forms the new schedule in ALIGN.
  // FINISH waits for the result register to be free, so a result that is
  // still waiting never blocks acceptance of the next item in IDLE.
  // --------------------------------------------------------------------------
  assign cnt_last  = (cnt == CNT_W'(TIME_BITS - 1));
  assign now_zero  = (time_now == '0);
  assign slot_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (action)
            ACT_POLL: begin
              if (scan_busy || !is_locked || now_zero) begin
                state_next = S_FINISH;
              end else begin
                state_next = S_POLL;
              end
            end
            ACT_BEACON: begin
              if (is_locked) begin
                state_next = S_FINISH;
              end else if (reg_period == '0) begin
                state_next = S_ALIGN;
              end else begin
                state_next = S_DIV;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_POLL: begin
        if (cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        if (cnt_last) begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall    = (state != S_IDLE);
    accept        = item_valid && (state == S_IDLE);
    load_result   = (state == S_FINISH) && slot_free;
    div_ctl.clear = accept;
    div_ctl.step  = (state == S_DIV);
    div_ctl.shift = (state == S_ALIGN);
    div_ctl.din   = osh[TIME_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Bit-serial remainder of the beacon time by the scan period.
  // --------------------------------------------------------------------------
  psws_div u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .period (reg_period),
    .rem    (rem)
  );

  // --------------------------------------------------------------------------
  // Shared serial adder. With r the remainder, the aligned boundary
  // (floor(b / p) + 1) * p equals b - r + p, so ALIGN sums
  // b + ~r + p + sext(phase) + 1 one bit per cycle with a two-bit carry.
  // A zero period skips DIV; the remainder and period terms are then zero
  // and the boundary is the beacon time itself. In POLL the same adder
  // forms next_scan_time + period while a borrow chain compares the current
  // time against next_scan_time.
  // --------------------------------------------------------------------------
  always_comb begin
    add_a     = (state == S_POLL) ? nst[0] : osh[0];
    add_nr    = (state == S_ALIGN) && !rem[0];
    add_ph    = (state == S_ALIGN) && phsh[0];
    add_total = {2'b00, add_a} + {2'b00, add_nr} + {2'b00, psh[0]}
              + {2'b00, add_ph} + {1'b0, cy};
    bw_next   = (!osh[0] && nst[0]) || (!(osh[0] ^ nst[0]) && bw);
    ssh_next  = {add_total[0], ssh[TIME_BITS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if ((state == S_POLL) || (state == S_DIV) || (state == S_ALIGN)) begin
      cnt <= cnt_last ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      osh     <= (action == ACT_BEACON) ? beacon_time : time_now;
      psh     <= reg_period;
      phsh    <= reg_phase;
      cy      <= (action == ACT_BEACON) ? 2'd1 : 2'd0;
      bw      <= 1'b0;
      start_r <= (action == ACT_POLL) && !scan_busy && (!is_locked || now_zero)
                 && reg_b2b;
    end else begin
      case (state)
        S_POLL: begin
          osh <= {1'b0, osh[TIME_BITS-1:1]};
          psh <= {1'b0, psh[PERIOD_W-1:1]};
          ssh <= ssh_next;
          cy  <= add_total[2:1];
          bw  <= bw_next;
          if (cnt_last) begin
            start_r <= !bw_next;
          end
        end
        S_DIV: begin
          osh <= {osh[TIME_BITS-2:0], osh[TIME_BITS-1]};
        end
        S_ALIGN: begin
          osh  <= {1'b0, osh[TIME_BITS-1:1]};
          psh  <= {1'b0, psh[PERIOD_W-1:1]};
          phsh <= {phsh[PHASE_W-1], phsh[PHASE_W-1:1]};
          ssh  <= ssh_next;
          cy   <= add_total[2:1];
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Scheduler state. next_scan_time rotates through POLL so it is intact at
  // the end; it takes the advanced value only when the scan starts.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      is_locked <= 1'b0;
      nst       <= '0;
    end else if (accept && (action == ACT_FORCE)) begin
      is_locked <= 1'b0;
      nst       <= '0;
    end else begin
      case (state)
        S_POLL: begin
          if (cnt_last && !bw_next) begin
            nst <= ssh_next;
          end else begin
            nst <= {nst[0], nst[TIME_BITS-1:1]};
          end
        end
        S_ALIGN: begin
          if (cnt_last) begin
            nst       <= ssh_next;
            is_locked <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It holds one result until the transfer completes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      start_scan <= start_r;
      duration   <= start_r ? reg_duration : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PSWS_ASSERT_NOW(a_idle_duration, result_valid && !start_scan, duration == '0,
    "duration is nonzero on a result without a scan start")
  `PSWS_ASSERT_NEXT(a_rem_below_period, (state == S_DIV) && cnt_last, rem < reg_period,
    "remainder is not below the scan period after the division")
  `PSWS_ASSERT_NEXT(a_align_locks, (state == S_ALIGN) && cnt_last,
    is_locked && (state == S_FINISH), "alignment did not lock the schedule")
  `PSWS_ASSERT_NEXT(a_force_clears, accept && (action == ACT_FORCE),
    !is_locked && (nst == '0), "force to prelock did not clear the schedule")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Scan window scheduler testbench
// Drives poll, beacon, force and unused-code items into the scheduler under
// several register settings. A scoreboard predicts the start flag and the
// scan duration of every item. Items pause and results stall at random.
// ----------------------------------------------------------------------------
module tb;
  import psws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names only the three defined actions; the fourth code is
  // legal on the wire and must be ignored by the block.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Run limit in clock cycles. The slowest correct run is roughly 1400 items,
  // each paying an aligning beacon, a long sender gap and a long result
  // stall; the limit takes that several times over.
  localparam int unsigned CYCLE_LIMIT = 1_200_000;

  // Cycles left after the last result before the final verdict. The tail
  // outlasts an aligning beacon, so this covers any straggler.
  localparam int unsigned TAIL_CYCLES = 2 * TIME_BITS + 16;

  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 150;

  // One scheduler decision as seen on the result channel, tagged with the
  // number of the item that caused it.
  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] dur;
    logic [31:0]      tag;
  } scan_decision_t;

  // One row of the directed table: either a register write or an item. Items
  // carry a typed-in decision only where it is obvious from the rules.
  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    val;
    logic [ACT_W-1:0]     act;
    logic [TIME_BITS-1:0] now;
    logic                 busy;
    logic [TIME_BITS-1:0] beacon;
    logic                 fixed;
    logic                 fx_start;
    logic [DUR_W-1:0]     fx_dur;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [ACT_W-1:0]     action = ACT_POLL;
  logic [TIME_BITS-1:0] time_now = '0;
  logic                 scan_busy = 1'b0;
  logic [TIME_BITS-1:0] beacon_time = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 start_scan;
  logic [DUR_W-1:0]     duration;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // Scoreboard copy of the registers and of the schedule state.
  logic                 cfg_b2b;
  logic [DUR_W-1:0]     cfg_dur;
  logic [PERIOD_W-1:0]  cfg_period;
  logic [PHASE_W-1:0]   cfg_phase;
  logic                 sched_locked;
  logic [TIME_BITS-1:0] sched_next;

  scan_decision_t pending_decisions[$];
  stim_row_t      directed[$];

  int unsigned error_count = 0;
  int unsigned item_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;   // when set, neither side idles

  periodic_scan_window_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .time_now     (time_now),
    .scan_busy    (scan_busy),
    .beacon_time  (beacon_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .start_scan   (start_scan),
    .duration     (duration),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding",
               cycle_count, pending_decisions.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // Sender gap before the next item: mostly none or a short one, sometimes
  // a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls in bursts that are usually short. The stall does
  // not look at result_valid, so it lands on every phase of the block's work.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      result_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Every result transfer is compared with the oldest pending decision.
  always @(posedge clk) begin : result_check
    scan_decision_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("result start=%b duration=%0d with none pending",
                                  start_scan, duration));
      end else begin
        want = pending_decisions.pop_front();
        if (start_scan !== want.start) begin
          report_mismatch($sformatf("item %0d start_scan %b, want %b",
                                    want.tag, start_scan, want.start));
        end
        if (duration !== want.dur) begin
          report_mismatch($sformatf("item %0d duration %0d, want %0d",
                                    want.tag, duration, want.dur));
        end
      end
    end
  end

  // Scoreboard step: applies one accepted item to the schedule copy and
  // queues the decision the block must produce for it. A typed-in decision,
  // where the row has one, replaces the computed one, but the state update
  // still happens.
  task automatic decide_scan(input logic [ACT_W-1:0] act,
                             input logic [TIME_BITS-1:0] now,
                             input logic busy,
                             input logic [TIME_BITS-1:0] beacon,
                             input logic fixed,
                             input logic fx_start,
                             input logic [DUR_W-1:0] fx_dur);
    scan_decision_t want;
    logic [63:0]    quot;
    logic [63:0]    bound;
    logic           go;
    go = 1'b0;
    case (act)
      ACT_POLL: begin
        if (!busy) begin
          // Unknown time behaves like the unlocked case even when locked.
          if (!sched_locked || now == '0) begin
            go = cfg_b2b;
          end else if (now >= sched_next) begin
            go = 1'b1;
            sched_next = sched_next + TIME_BITS'(cfg_period);
          end
        end
      end
      ACT_BEACON: begin
        // A beacon only aligns while unlocked; a zero period skips the
        // division and uses the beacon time as the boundary.
        if (!sched_locked) begin
          if (cfg_period == '0) begin
            bound = 64'(beacon);
          end else begin
            quot = 64'(beacon) / 64'(cfg_period);
            bound = (quot + 64'd1) * 64'(cfg_period);
          end
          bound = bound + {{(64 - PHASE_W){cfg_phase[PHASE_W-1]}}, cfg_phase};
          sched_next = bound[TIME_BITS-1:0];
          sched_locked = 1'b1;
        end
      end
      ACT_FORCE: begin
        sched_locked = 1'b0;
        sched_next = '0;
      end
      default: begin
      end
    endcase
    want.start = fixed ? fx_start : go;
    want.dur = fixed ? fx_dur : (go ? cfg_dur : '0);
    want.tag = item_count;
    pending_decisions.push_back(want);
  endtask

  // Sends one item. Valid stays high from the previous transfer when there
  // is no gap, so the payload simply changes at the accepting edge.
  task automatic send_item(input logic [ACT_W-1:0] act,
                           input logic [TIME_BITS-1:0] now,
                           input logic busy,
                           input logic [TIME_BITS-1:0] beacon,
                           input logic fixed,
                           input logic fx_start,
                           input logic [DUR_W-1:0] fx_dur);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    time_now <= now;
    scan_busy <= busy;
    beacon_time <= beacon;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    decide_scan(act, now, busy, beacon, fixed, fx_start, fx_dur);
    item_count++;
  endtask

  // Drops valid and waits until every pending decision has been checked.
  // Each item yields exactly one result, so the block is idle by then; the
  // short settle is only a margin.
  task automatic wait_for_idle();
    item_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle, completed on pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    wait_for_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_B2B:      cfg_b2b = val[0];
      REG_DURATION: cfg_dur = val[DUR_W-1:0];
      REG_PERIOD:   cfg_period = val[PERIOD_W-1:0];
      REG_PHASE:    cfg_phase = val[PHASE_W-1:0];
      default: begin
      end
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stim_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic [ACT_W-1:0] act,
                                         input logic [TIME_BITS-1:0] now,
                                         input logic busy,
                                         input logic [TIME_BITS-1:0] beacon);
    stim_row_t row;
    row = '0;
    row.act = act;
    row.now = now;
    row.busy = busy;
    row.beacon = beacon;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input logic [ACT_W-1:0] act,
                                          input logic [TIME_BITS-1:0] now,
                                          input logic busy,
                                          input logic [TIME_BITS-1:0] beacon,
                                          input logic start,
                                          input logic [DUR_W-1:0] dur);
    stim_row_t row;
    row = item_row(act, now, busy, beacon);
    row.fixed = 1'b1;
    row.fx_start = start;
    row.fx_dur = dur;
    return row;
  endfunction

  // Picks a time for a poll. When locked, most polls land just around the
  // next scan time so that both sides of the comparison are exercised.
  function automatic logic [TIME_BITS-1:0] pick_poll_time();
    int unsigned r;
    int          delta;
    r = $urandom_range(0, 99);
    delta = int'($urandom_range(0, 6)) - 3;
    if (r < 8) begin
      return '0;
    end else if (sched_locked && r < 85) begin
      return sched_next + TIME_BITS'(delta);
    end
    return rand_time();
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_beacon_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return rand_time();
    end else if (r < 70) begin
      return TIME_MAX - TIME_BITS'($urandom_range(0, 40000));
    end
    return TIME_BITS'($urandom_range(0, 50000));
  endfunction

  // Register setting for one random phase; the first phases take the
  // extremes, the later ones random values.
  task automatic load_phase_regs(input int unsigned ph);
    logic [DATA_W-1:0] per;
    logic [DATA_W-1:0] dur;
    logic [DATA_W-1:0] phs;
    case (ph % 3)
      0: dur = 32'd0;
      1: dur = 32'd65535;
      default: dur = $urandom_range(0, 65535);
    endcase
    case (ph)
      0: per = 32'd1;
      1: per = 32'hFF_FFFF;
      2: per = $urandom_range(1, 8);
      default: per = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 50)
                                                 : $urandom_range(1, 16777215);
    endcase
    case (ph)
      0: phs = 32'h0000_8000;
      1: phs = 32'h0000_7FFF;
      2: phs = 32'd0;
      default: phs = $urandom_range(0, 65535);
    endcase
    write_reg(REG_B2B, 32'(ph[0] ^ ph[2]));
    write_reg(REG_DURATION, dur);
    write_reg(REG_PERIOD, per);
    write_reg(REG_PHASE, phs);
  endtask

  initial begin : stimulus
    stim_row_t            row;
    int unsigned          useful;
    int unsigned          r;
    logic [ACT_W-1:0]     act;
    logic [TIME_BITS-1:0] now;
    logic                 busy;
    logic [TIME_BITS-1:0] beacon;

    // Scoreboard state after reset.
    cfg_b2b = 1'b0;
    cfg_dur = DURATION_RESET;
    cfg_period = PERIOD_RESET;
    cfg_phase = '0;
    sched_locked = 1'b0;
    sched_next = '0;

    // Directed table. Reset values first: back-to-back off, so unlocked
    // polls never start a scan, and the unused action code does nothing.
    directed.push_back(fixed_row(ACT_POLL, '0, 1'b0, '0, 1'b0, 16'd0));
    directed.push_back(fixed_row(ACT_POLL, TIME_MAX, 1'b0, TIME_MAX, 1'b0, 16'd0));
    directed.push_back(fixed_row(ACT_UNUSED, TIME_MAX, 1'b1, TIME_MAX, 1'b0, 16'd0));
    // Back-to-back on: idle unlocked polls start at once, busy ones do not.
    directed.push_back(cfg_row(REG_B2B, 32'd1));
    directed.push_back(fixed_row(ACT_POLL, 48'd5, 1'b0, '0, 1'b1, DURATION_RESET));
    directed.push_back(fixed_row(ACT_POLL, 48'd5, 1'b1, '0, 1'b0, 16'd0));
    directed.push_back(cfg_row(REG_DURATION, 32'd65535));
    directed.push_back(fixed_row(ACT_POLL, '0, 1'b0, TIME_MAX, 1'b1, 16'd65535));
    // Lock on a beacon; a second beacon while locked is ignored.
    directed.push_back(fixed_row(ACT_BEACON, '0, 1'b0, 48'd12345, 1'b0, 16'd0));
    directed.push_back(fixed_row(ACT_BEACON, TIME_MAX, 1'b0, '0, 1'b0, 16'd0));
    directed.push_back(item_row(ACT_POLL, 48'd12999, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, 48'd13000, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, 48'd13999, 1'b0, '0));
    // Locked poll with unknown time falls back to back-to-back behavior.
    directed.push_back(item_row(ACT_POLL, '0, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, TIME_MAX, 1'b1, '0));
    directed.push_back(fixed_row(ACT_FORCE, TIME_MAX, 1'b1, TIME_MAX, 1'b0, 16'd0));
    directed.push_back(cfg_row(REG_B2B, 32'd0));
    directed.push_back(fixed_row(ACT_POLL, TIME_MAX, 1'b0, '0, 1'b0, 16'd0));
    // Largest period with the most negative offset, beacon at the top of the
    // time range so the boundary overflows and wraps.
    directed.push_back(cfg_row(REG_PHASE, 32'h0000_8000));
    directed.push_back(cfg_row(REG_PERIOD, 32'hFF_FFFF));
    directed.push_back(item_row(ACT_BEACON, '0, 1'b0, TIME_MAX));
    directed.push_back(item_row(ACT_POLL, TIME_MAX, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, TIME_MAX, 1'b0, '0));
    directed.push_back(fixed_row(ACT_FORCE, '0, 1'b0, '0, 1'b0, 16'd0));
    // Zero period: the beacon time itself is the boundary; the negative
    // offset wraps it below zero.
    directed.push_back(cfg_row(REG_PERIOD, 32'd0));
    directed.push_back(item_row(ACT_BEACON, 48'd1, 1'b0, 48'd100));
    directed.push_back(item_row(ACT_POLL, 48'd1, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, TIME_MAX, 1'b0, '0));
    directed.push_back(fixed_row(ACT_FORCE, '0, 1'b0, '0, 1'b0, 16'd0));
    // Smallest period with the largest offset; the boundary after the top
    // beacon time is exactly 2^48 and wraps to zero before the offset.
    directed.push_back(cfg_row(REG_PHASE, 32'h0000_7FFF));
    directed.push_back(cfg_row(REG_PERIOD, 32'd1));
    directed.push_back(item_row(ACT_BEACON, '0, 1'b0, TIME_MAX));
    directed.push_back(item_row(ACT_POLL, 48'd32765, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, 48'd32766, 1'b0, '0));
    directed.push_back(item_row(ACT_POLL, 48'd32767, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.val);
      end else begin
        send_item(row.act, row.now, row.busy, row.beacon,
                  row.fixed, row.fx_start, row.fx_dur);
      end
    end

    // Random phases. Each takes a new register setting and carries on from
    // the schedule that the one before left behind. Items that change
    // nothing (busy polls, the unused code, beacons while locked) do not
    // count toward the phase length.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      load_phase_regs(ph);
      quiet = (ph % 4 == 3);
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        // Midway through phase 2 the sender holds off until everything is back.
        if (ph == 2 && useful == PHASE_ITEMS / 2) begin
          wait_for_idle();
        end
        r = $urandom_range(0, 99);
        busy = ($urandom_range(0, 9) == 0);
        now = rand_time();
        beacon = rand_time();
        if (r < (sched_locked ? 5 : 30)) begin
          act = ACT_BEACON;
          beacon = pick_beacon_time();
        end else if (r < 36) begin
          act = sched_locked ? ACT_FORCE : ACT_BEACON;
        end else if (r < 40) begin
          act = ACT_UNUSED;
        end else if (r < 43) begin
          act = ACT_BEACON;
        end else begin
          act = ACT_POLL;
          now = pick_poll_time();
        end
        if (!((act == ACT_POLL && busy) || act == ACT_UNUSED ||
              (act == ACT_BEACON && sched_locked))) begin
          useful++;
        end
        send_item(act, now, busy, beacon, 1'b0, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
